// File: hdl/sfpr_pkg.sv
// Shared types and constants of the sync-framed packet receiver.
package sfpr_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 8;
    localparam int BYTE_W = 8;
    localparam int LEN_W = 6;
    localparam int IDX_W = 5;
    // compare width for lengths and fill counts (length register and depth fit in 7 bits)
    localparam int LEN_CMP_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 8'd2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST = 8'h7B;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hEA;
    localparam logic [LEN_W-1:0] PAYLOAD_LENGTH_RST = 6'd20;

    typedef struct packed {
        logic frame_clr;
        logic store;
        logic rd_start;
        logic rd_issue;
        logic err_issue;
    } t_cmd;

    typedef struct packed {
        logic sync1_hit;
        logic sync2_hit;
        logic fill_done;
        logic sum_hit;
        logic rd_last;
        logic slot_free;
    } t_status;

endpackage

// File: hdl/sfpr_ctrl.sv
// Frame controller: hunt, sync check, payload fill, checksum and result sequencing.
module sfpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sfpr_pkg::t_status i_status,
    output sfpr_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] ST_HUNT  = 3'd0;
    localparam logic [2:0] ST_SYNC1 = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_ERR   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    // receive states take bytes; emit states hold input off
    assign o_ready = ~r_state[2];
    assign accept  = i_valid & o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_HUNT: begin
                if (accept && i_status.sync1_hit) n_state = ST_SYNC1;
            end
            ST_SYNC1: begin
                if (accept) begin
                    if (i_status.sync2_hit) begin
                        o_cmd.frame_clr = 1'b1;
                        n_state = ST_FILL;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
            end
            ST_FILL: begin
                if (accept) begin
                    o_cmd.store = 1'b1;
                    if (i_status.fill_done) n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (accept) begin
                    if (i_status.sum_hit) begin
                        o_cmd.rd_start = 1'b1;
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_ERR;
                    end
                end
            end
            ST_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.rd_issue = 1'b1;
                    if (i_status.rd_last) n_state = ST_HUNT;
                end
            end
            ST_ERR: begin
                if (i_status.slot_free) begin
                    o_cmd.err_issue = 1'b1;
                    n_state = ST_HUNT;
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/sfpr_dp.sv
// Datapath: config registers, checksum, payload buffer and two-stage result pipeline.
module sfpr_dp #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [sfpr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sfpr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [sfpr_pkg::BYTE_W-1:0]          i_rx_byte,
    input  sfpr_pkg::t_cmd                       i_cmd,
    output sfpr_pkg::t_status                    o_status,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output logic                                 o_frame_error,
    output logic [sfpr_pkg::BYTE_W-1:0]          o_payload_byte,
    output logic [sfpr_pkg::IDX_W-1:0]           o_byte_index,
    output logic                                 o_last
);

    localparam int FW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [sfpr_pkg::LEN_CMP_W-1:0] MAX_CMP = sfpr_pkg::LEN_CMP_W'(MAX_PAYLOAD);

    logic [sfpr_pkg::BYTE_W-1:0] r_sync1;
    logic [sfpr_pkg::BYTE_W-1:0] r_sync2;
    logic [sfpr_pkg::LEN_W-1:0]  r_len;
    logic [sfpr_pkg::BYTE_W-1:0] r_sum;
    logic [FW-1:0]               r_fill;
    logic [FW-1:0]               r_rd_idx;
    logic [sfpr_pkg::BYTE_W-1:0] r_mem [MAX_PAYLOAD];

    logic                        r_pend;
    logic                        r_p_err;
    logic [sfpr_pkg::BYTE_W-1:0] r_p_byte;
    logic [sfpr_pkg::IDX_W-1:0]  r_p_idx;
    logic                        r_p_last;

    logic                        r_ov;
    logic                        r_o_err;
    logic [sfpr_pkg::BYTE_W-1:0] r_o_byte;
    logic [sfpr_pkg::IDX_W-1:0]  r_o_idx;
    logic                        r_o_last;

    logic [sfpr_pkg::LEN_CMP_W-1:0] eff_len;
    logic [sfpr_pkg::LEN_CMP_W-1:0] len_ext;
    logic                           fill_room;
    logic [FW-1:0]                  fill_next;
    logic [FW-1:0]                  rd_next;
    logic                           load;
    logic                           issue;

    assign len_ext = sfpr_pkg::LEN_CMP_W'(r_len);

    // clamp length to 1..MAX_PAYLOAD
    always_comb begin
        if (r_len == '0) begin
            eff_len = sfpr_pkg::LEN_CMP_W'(1);
        end else if (len_ext > MAX_CMP) begin
            eff_len = MAX_CMP;
        end else begin
            eff_len = len_ext;
        end
    end

    assign fill_room = sfpr_pkg::LEN_CMP_W'(r_fill) < MAX_CMP;
    assign fill_next = fill_room ? FW'(r_fill + 1'b1) : r_fill;
    assign rd_next   = FW'(r_rd_idx + 1'b1);

    assign load  = r_pend & (~r_ov | i_ready);
    assign issue = i_cmd.rd_issue | i_cmd.err_issue;

    assign o_status.sync1_hit = (i_rx_byte == r_sync1);
    assign o_status.sync2_hit = (i_rx_byte == r_sync2);
    assign o_status.fill_done = (sfpr_pkg::LEN_CMP_W'(fill_next) >= eff_len);
    assign o_status.sum_hit   = (i_rx_byte == r_sum);
    assign o_status.rd_last   = (rd_next == r_fill);
    assign o_status.slot_free = ~r_pend | load;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync1 <= sfpr_pkg::SYNC_FIRST_RST;
            r_sync2 <= sfpr_pkg::SYNC_SECOND_RST;
            r_len   <= sfpr_pkg::PAYLOAD_LENGTH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sfpr_pkg::REG_SYNC_FIRST:     r_sync1 <= i_cfg_data;
                sfpr_pkg::REG_SYNC_SECOND:    r_sync2 <= i_cfg_data;
                sfpr_pkg::REG_PAYLOAD_LENGTH: r_len   <= i_cfg_data[sfpr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // running sum, fill count and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_fill   <= '0;
            r_rd_idx <= '0;
        end else begin
            if (i_cmd.frame_clr) begin
                r_sum  <= '0;
                r_fill <= '0;
            end else if (i_cmd.store) begin
                r_sum  <= r_sum + i_rx_byte;
                r_fill <= fill_next;
            end
            if (i_cmd.rd_start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_issue) begin
                r_rd_idx <= rd_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && fill_room) begin
            r_mem[r_fill[AW-1:0]] <= i_rx_byte;
        end
    end

    // read stage: registered buffer read or error result
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_p_byte <= r_mem[r_rd_idx[AW-1:0]];
            r_p_err  <= 1'b0;
            r_p_idx  <= sfpr_pkg::IDX_W'(r_rd_idx);
            r_p_last <= o_status.rd_last;
        end else if (i_cmd.err_issue) begin
            r_p_byte <= '0;
            r_p_err  <= 1'b1;
            r_p_idx  <= '0;
            r_p_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_err  <= r_p_err;
            r_o_byte <= r_p_byte;
            r_o_idx  <= r_p_idx;
            r_o_last <= r_p_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (issue) begin
                r_pend <= 1'b1;
            end else if (load) begin
                r_pend <= 1'b0;
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ov;
    assign o_frame_error  = r_o_err;
    assign o_payload_byte = r_o_byte;
    assign o_byte_index   = r_o_idx;
    assign o_last         = r_o_last;

endmodule

// File: hdl/sync_framed_packet_receiver.sv
// Top level of the sync-framed packet receiver.
//
// Input channel (i_valid / o_ready / i_rx_byte) takes one received byte per request.
// The block hunts for the first sync byte, expects the second sync byte right after,
// then buffers payload_length bytes, clamped to 1..MAX_PAYLOAD, while summing them
// modulo 256. The next byte is the checksum. A match emits the buffered payload on the
// output channel (o_valid / i_ready), one request per byte with o_byte_index and o_last
// on the final byte; a mismatch emits a single request with o_frame_error set and
// o_last high. Throughput: one input byte per cycle while receiving. After the checksum
// is taken, input is held off while the payload bytes are issued from the buffer through
// its single read port, one per cycle while the output does not stall; an error result
// is issued once. Each result passes the buffer read stage, then the output register.
// A stalled receiver holds the output register and the read stage, and the controller
// waits; input stays held until all results of the frame are issued.
// Configuration port (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) is always
// ready: 0 first sync, 1 second sync, 2 payload length; other indexes are dropped.
// Synchronous active-low reset restores register defaults and starts hunting.
module sync_framed_packet_receiver #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sfpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [sfpr_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_frame_error,
    output logic [sfpr_pkg::BYTE_W-1:0]     o_payload_byte,
    output logic [sfpr_pkg::IDX_W-1:0]      o_byte_index,
    output logic                            o_last
);

    sfpr_pkg::t_cmd    cmd;
    sfpr_pkg::t_status status;

    // registers accept writes at any time
    assign o_cfg_ready = 1'b1;

    sfpr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sfpr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_frame_error  (o_frame_error),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last         (o_last)
    );

endmodule

// File: bench/sync_framed_packet_receiver_tb.sv
// Self-checking bench for the sync-framed packet receiver: directed table, then random frames.
module sync_framed_packet_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int PAYLOAD_DEPTH = 32;
    localparam int ITEMS_TARGET  = 470;
    // cycles to let a request that causes no result settle before a register write
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 20000;

    // receive state of the frame tracker
    localparam logic [1:0] RX_HUNT  = 2'd0;
    localparam logic [1:0] RX_SYNC1 = 2'd1;
    localparam logic [1:0] RX_FILL  = 2'd2;
    localparam logic [1:0] RX_CHECK = 2'd3;

    typedef struct packed {
        logic                        frame_error;
        logic [sfpr_pkg::BYTE_W-1:0] payload_byte;
        logic [sfpr_pkg::IDX_W-1:0]  byte_index;
        logic                        last;
    } t_frame_result;

    // one row of the directed table: a register write or a received byte
    typedef struct packed {
        logic                            is_cfg;
        logic [sfpr_pkg::CFG_IDX_W-1:0]  index;
        logic [sfpr_pkg::CFG_DATA_W-1:0] value;
        logic                            typed;
        t_frame_result                   res;
    } t_stim_row;

    localparam t_frame_result SUM_ERROR_RESULT = t_frame_result'({1'b1, 8'h00, 5'd0, 1'b1});

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [sfpr_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [sfpr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [sfpr_pkg::BYTE_W-1:0]     i_rx_byte = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic                            o_frame_error;
    logic [sfpr_pkg::BYTE_W-1:0]     o_payload_byte;
    logic [sfpr_pkg::IDX_W-1:0]      o_byte_index;
    logic                            o_last;

    sync_framed_packet_receiver #(
        .MAX_PAYLOAD(PAYLOAD_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_rx_byte(i_rx_byte),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_frame_error(o_frame_error),
        .o_payload_byte(o_payload_byte),
        .o_byte_index(o_byte_index),
        .o_last(o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Frame tracker: own copy of registers and receive state.
    logic [sfpr_pkg::BYTE_W-1:0] trk_sync_first  = sfpr_pkg::SYNC_FIRST_RST;
    logic [sfpr_pkg::BYTE_W-1:0] trk_sync_second = sfpr_pkg::SYNC_SECOND_RST;
    logic [sfpr_pkg::LEN_W-1:0]  trk_length      = sfpr_pkg::PAYLOAD_LENGTH_RST;
    logic [1:0]                  trk_phase       = RX_HUNT;
    logic [sfpr_pkg::BYTE_W-1:0] trk_sum         = '0;
    int                          trk_fill        = 0;
    logic [sfpr_pkg::BYTE_W-1:0] trk_store [PAYLOAD_DEPTH];

    t_frame_result step_results[$];      // results caused by the byte just accepted
    t_frame_result frame_results_due[$]; // results still owed by the block
    t_stim_row     directed_rows[$];

    int  fail_count      = 0;
    int  bytes_sent      = 0;
    int  results_checked = 0;
    int  sum_errors_seen = 0;
    int  settings_used   = 0;
    bit  calm_tail       = 1'b0;
    int  ready_hold      = 0;

    // Advance the tracker by one received byte; fill step_results.
    function automatic void track_rx_byte(input logic [sfpr_pkg::BYTE_W-1:0] b);
        int eff_len;
        int n;
        t_frame_result r;
        step_results.delete();
        eff_len = (trk_length == 0) ? 1 :
                  (int'(trk_length) > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(trk_length);
        unique case (trk_phase)
            RX_HUNT: begin
                if (b == trk_sync_first) trk_phase = RX_SYNC1;
            end
            RX_SYNC1: begin
                // a wrong second byte is dropped, not retried as a first sync
                if (b == trk_sync_second) begin
                    trk_sum = '0;
                    trk_fill = 0;
                    trk_phase = RX_FILL;
                end else begin
                    trk_phase = RX_HUNT;
                end
            end
            RX_FILL: begin
                if (trk_fill < PAYLOAD_DEPTH) begin
                    trk_store[trk_fill] = b;
                    trk_fill++;
                end
                trk_sum = trk_sum + b;
                // length is read live: a shrink mid-frame ends the fill early
                if (trk_fill >= eff_len) trk_phase = RX_CHECK;
            end
            default: begin
                if (b == trk_sum) begin
                    // emit what was stored, whatever the length register says now
                    n = (trk_fill > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : trk_fill;
                    for (int i = 0; i < n; i++) begin
                        r.frame_error  = 1'b0;
                        r.payload_byte = trk_store[i];
                        r.byte_index   = sfpr_pkg::IDX_W'(i);
                        r.last         = (i + 1 == n);
                        step_results.push_back(r);
                    end
                end else begin
                    step_results.push_back(SUM_ERROR_RESULT);
                end
                trk_phase = RX_HUNT;
            end
        endcase
    endfunction

    function automatic void track_cfg(input logic [sfpr_pkg::CFG_IDX_W-1:0]  idx,
                                      input logic [sfpr_pkg::CFG_DATA_W-1:0] data);
        unique case (idx)
            sfpr_pkg::REG_SYNC_FIRST:     trk_sync_first = data;
            sfpr_pkg::REG_SYNC_SECOND:    trk_sync_second = data;
            sfpr_pkg::REG_PAYLOAD_LENGTH: trk_length = data[sfpr_pkg::LEN_W-1:0];
            default: ; // drop writes to unknown indexes
        endcase
    endfunction

    function automatic logic [sfpr_pkg::BYTE_W-1:0] pick_sync_value();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return sfpr_pkg::BYTE_W'($urandom);
        endcase
    endfunction

    // Send one byte request; call right after a rising edge. Returns at the accepting edge.
    task automatic push_byte(input logic [sfpr_pkg::BYTE_W-1:0] b, input logic typed,
                             input t_frame_result typed_res);
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            // hold off the sender for a burst
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
        if (bytes_sent >= ITEMS_TARGET - 50) calm_tail = 1'b1;
        track_rx_byte(b);
        if (typed) begin
            frame_results_due.push_back(typed_res);
        end else begin
            foreach (step_results[k]) frame_results_due.push_back(step_results[k]);
        end
    endtask

    // Write a register once the block has gone quiet; call right after a rising edge.
    task automatic write_reg(input logic [sfpr_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [sfpr_pkg::CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        while (frame_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        track_cfg(idx, data);
    endtask

    task automatic add_rx(input logic [sfpr_pkg::BYTE_W-1:0] b);
        directed_rows.push_back('{is_cfg: 1'b0, index: '0, value: b, typed: 1'b0, res: '0});
    endtask

    task automatic add_rx_typed(input logic [sfpr_pkg::BYTE_W-1:0] b, input t_frame_result r);
        directed_rows.push_back('{is_cfg: 1'b0, index: '0, value: b, typed: 1'b1, res: r});
    endtask

    task automatic add_cfg(input logic [sfpr_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [sfpr_pkg::CFG_DATA_W-1:0] data);
        directed_rows.push_back('{is_cfg: 1'b1, index: idx, value: data, typed: 1'b0, res: '0});
    endtask

    // Receiver side: stall in bursts of random length, none in the tail.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            i_ready <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            ready_hold = $urandom_range(1, 16) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Check every accepted result request against the oldest one owed.
    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (frame_results_due.size() == 0) begin
                $error("unexpected result: error=%0d byte=%0h index=%0d last=%0d",
                       o_frame_error, o_payload_byte, o_byte_index, o_last);
                fail_count++;
            end else begin
                want = frame_results_due.pop_front();
                results_checked++;
                if (want.frame_error) sum_errors_seen++;
                if (o_frame_error !== want.frame_error) begin
                    $error("frame_error: expected %0d, got %0d", want.frame_error, o_frame_error);
                    fail_count++;
                end
                if (o_payload_byte !== want.payload_byte) begin
                    $error("payload_byte: expected %0h, got %0h", want.payload_byte, o_payload_byte);
                    fail_count++;
                end
                if (o_byte_index !== want.byte_index) begin
                    $error("byte_index: expected %0d, got %0d", want.byte_index, o_byte_index);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(10_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [sfpr_pkg::BYTE_W-1:0]     sf;
        logic [sfpr_pkg::BYTE_W-1:0]     ss;
        logic [sfpr_pkg::CFG_DATA_W-1:0] len_data;
        logic [sfpr_pkg::LEN_W-1:0]      len_low;
        logic [sfpr_pkg::BYTE_W-1:0]     b;
        logic [sfpr_pkg::BYTE_W-1:0]     sum;
        int                              eff_len;
        int                              n_frames;
        int                              wait_cycles;

        // Directed table. Reset values first: 0x7B / 0xEA, then the special cases.
        add_rx(8'h00);                          // hunting, no sync
        add_rx(8'h7B);                          // first sync
        add_rx(8'h7B);                          // wrong second byte: drop, not a new first sync
        add_rx(8'hEA);                          // ignored while hunting
        add_rx(8'h7B);
        add_rx(8'hEA);                          // into fill with length 20
        add_cfg(sfpr_pkg::REG_PAYLOAD_LENGTH, 8'h00); // shrink while storing; zero acts as one
        add_rx(8'hFF);
        add_rx_typed(8'hFE, SUM_ERROR_RESULT);  // checksum mismatch
        add_rx(8'h7B);
        add_rx(8'hEA);
        add_rx(8'hFF);
        add_rx_typed(8'hFF, t_frame_result'({1'b0, 8'hFF, 5'd0, 1'b1}));
        add_cfg(sfpr_pkg::REG_SYNC_FIRST, 8'h00);
        add_cfg(sfpr_pkg::REG_SYNC_SECOND, 8'hFF);
        add_rx(8'h00);                          // first sync with the new value
        add_cfg(sfpr_pkg::REG_SYNC_SECOND, 8'h00); // change the second sync mid-frame
        add_rx(8'h00);                          // matches the new second sync
        add_cfg(sfpr_pkg::REG_PAYLOAD_LENGTH, 8'h02);
        add_rx(8'h80);
        add_rx(8'h01);                          // now awaiting checksum
        add_cfg(sfpr_pkg::REG_PAYLOAD_LENGTH, 8'hC5); // grow to 5 while awaiting checksum
        add_rx(8'h81);                          // good: emits the two stored bytes
        add_cfg(8'h03, 8'hAA);                  // unknown indexes are dropped
        add_cfg(8'hFF, 8'h55);
        add_rx(8'h00);
        add_rx(8'h00);
        add_rx(8'h01);
        add_rx(8'h02);
        add_rx(8'h04);
        add_rx(8'h08);
        add_rx(8'h10);
        add_rx(8'h1F);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg) begin
                write_reg(directed_rows[r].index, directed_rows[r].value);
            end else begin
                push_byte(directed_rows[r].value, directed_rows[r].typed, directed_rows[r].res);
            end
        end
        settings_used = 4;

        // Random part: new register setting per phase, then a few frames.
        while (bytes_sent < ITEMS_TARGET) begin
            sf = pick_sync_value();
            ss = ($urandom_range(0, 7) == 0) ? sf : pick_sync_value();
            len_data = sfpr_pkg::CFG_DATA_W'($urandom);
            case ($urandom_range(0, 15))
                0:       len_low = '0;
                1:       len_low = sfpr_pkg::LEN_W'($urandom_range(PAYLOAD_DEPTH + 1, 63));
                2:       len_low = sfpr_pkg::LEN_W'(PAYLOAD_DEPTH);
                3:       len_low = sfpr_pkg::LEN_W'($urandom_range(7, PAYLOAD_DEPTH - 1));
                default: len_low = sfpr_pkg::LEN_W'($urandom_range(1, 6));
            endcase
            len_data[sfpr_pkg::LEN_W-1:0] = len_low;
            write_reg(sfpr_pkg::REG_SYNC_FIRST, sf);
            write_reg(sfpr_pkg::REG_SYNC_SECOND, ss);
            write_reg(sfpr_pkg::REG_PAYLOAD_LENGTH, len_data);
            if ($urandom_range(0, 5) == 0)
                write_reg(sfpr_pkg::CFG_IDX_W'($urandom_range(3, 255)),
                          sfpr_pkg::CFG_DATA_W'($urandom));
            settings_used++;
            eff_len = (len_low == 0) ? 1 :
                      (int'(len_low) > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(len_low);

            n_frames = $urandom_range(2, 5);
            for (int f = 0; f < n_frames; f++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        // line noise
                        repeat ($urandom_range(1, 4))
                            push_byte(sfpr_pkg::BYTE_W'($urandom), 1'b0, '0);
                    end
                    1: begin
                        // broken sync pair
                        b = sfpr_pkg::BYTE_W'($urandom);
                        if (b == ss) b = b ^ 8'h01;
                        push_byte(sf, 1'b0, '0);
                        push_byte(b, 1'b0, '0);
                    end
                    default: begin
                        // well-formed frame with random payload; the checksum is sometimes corrupted
                        push_byte(sf, 1'b0, '0);
                        push_byte(ss, 1'b0, '0);
                        sum = '0;
                        for (int k = 0; k < eff_len; k++) begin
                            b = sfpr_pkg::BYTE_W'($urandom);
                            sum = sum + b;
                            push_byte(b, 1'b0, '0);
                        end
                        if ($urandom_range(0, 3) == 0)
                            sum = sum ^ sfpr_pkg::BYTE_W'($urandom_range(1, 255));
                        push_byte(sum, 1'b0, '0);
                    end
                endcase
            end
        end

        // Drain: drop valid and let every owed result arrive.
        i_valid <= 1'b0;
        wait_cycles = 0;
        while (frame_results_due.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (frame_results_due.size() != 0) begin
            $error("%0d expected results never arrived", frame_results_due.size());
            fail_count++;
        end

        $display("Sent %0d bytes under %0d register settings, with stalls on both sides.",
                 bytes_sent, settings_used);
        $display("Checked %0d results, %0d of them checksum errors.",
                 results_checked, sum_errors_seen);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
